// File: rtl/pip_pkg.sv
// Package for the even-odd point-in-polygon core.
// Holds the fixed port widths, the request action codes and the query sequencer state type.
// Depends on nothing; imported by point_in_polygon_even_odd_core and tb_top.
package pip_pkg;

    // Fixed port widths
    localparam int IDX_W   = 8;
    localparam int IN_CW   = 32;

    // Request actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Query sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FINISH
    } t_state;

endpackage

// File: rtl/point_in_polygon_even_odd_core.sv
// Even-odd ray-casting point-in-polygon core with an on-chip vertex table.
// Depends on pip_pkg for port widths, action codes and the sequencer state.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  request | in        | i_valid / o_ready  | action, vertex_index, last_vertex, coord_x/y
//  result  | out       | o_valid / i_ready  | inside_res (one per query, none per load)
//
// A query over N stored vertices walks the table; the vertex memory has one read port,
// so the walk issues N + 1 reads (the closing vertex first, then slots 0 .. N-1) and then
// drains a three-stage edge pipeline. Reset is synchronous, active low; it clears the
// vertex count and all control state, while the table contents stay undefined until
// loaded. A stalled result holds in the output register; loads are still taken, and a
// new query waits at its end for the slot.
module point_in_polygon_even_odd_core #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [pip_pkg::IDX_W-1:0]  i_vertex_index,
    input  logic                       i_last_vertex,
    input  logic [pip_pkg::IN_CW-1:0]  i_coord_x,
    input  logic [pip_pkg::IN_CW-1:0]  i_coord_y,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_inside_res
);
    import pip_pkg::*;

    localparam int SLOTS = 1 << IDX_W;
    localparam int DEPTH = (MAX_VERTICES < SLOTS) ? MAX_VERTICES : SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;

    // Vertex table: x in the high half, y in the low half
    logic [2*CW-1:0] r_mem [DEPTH];

    t_state r_state, n_state;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_last;
    logic [CNT_W-1:0]      r_cnt;
    logic [AW-1:0]         r_addr;
    logic                  r_jphase;
    logic signed [CW-1:0]  r_qx, r_qy;
    logic                  r_parity;

    logic                  r_p1_rd, r_p1_edge;
    logic [2*CW-1:0]       r_rd_data;
    logic [2*CW-1:0]       r_prev;

    logic                  r_s2_v, r_s2_cross, r_s2_dpos;
    logic signed [DW-1:0]  r_s2_a, r_s2_d, r_s2_b, r_s2_e;

    logic                  r_s3_v, r_s3_cross, r_s3_dpos;
    logic signed [PW-1:0]  r_s3_pl, r_s3_pr;

    logic                  r_out_valid, r_inside;

    logic                  w_accept, w_load, w_query, w_slot_ok;
    logic                  w_wr_en, w_rd_en, w_last_read, w_pipe_empty, w_out_free;
    logic                  w_load_out;
    logic signed [CW-1:0]  w_xi, w_yi, w_xj, w_yj;
    logic                  w_left;

    assign w_accept     = i_valid && o_ready;
    assign w_load       = w_accept && (i_action == ACT_LOAD);
    assign w_query      = w_accept && (i_action == ACT_QUERY);
    assign w_slot_ok    = {1'b0, i_vertex_index} < (IDX_W + 1)'(DEPTH);
    assign w_wr_en      = w_load && w_slot_ok;
    assign w_last_read  = !r_jphase && (r_cnt == r_last);
    assign w_pipe_empty = !r_p1_rd && !r_s2_v && !r_s3_v;
    assign w_out_free   = !r_out_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = (r_count == '0) ? ST_FINISH : ST_READ;
                end
            end
            ST_READ: begin
                if (w_last_read) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_pipe_empty && w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready    = 1'b0;
        w_rd_en    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE:   o_ready    = 1'b1;
            ST_READ:   w_rd_en    = 1'b1;
            ST_FINISH: w_load_out = w_pipe_empty && w_out_free;
            default: begin
                o_ready    = 1'b0;
                w_rd_en    = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Write loads, read one slot per walk cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[i_vertex_index[AW-1:0]] <= {i_coord_x[CW-1:0], i_coord_y[CW-1:0]};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Vertex count: set by the final vertex of a load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_wr_en && i_last_vertex) begin
            r_count <= CNT_W'({1'b0, i_vertex_index} + (IDX_W + 1)'(1));
        end
    end

    // Walk addresses: closing vertex first, then slots 0 .. count-1
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_addr   <= AW'(r_count - CNT_W'(1));
            r_last   <= r_count - CNT_W'(1);
            r_cnt    <= '0;
            r_jphase <= 1'b1;
            r_qx     <= i_coord_x[CW-1:0];
            r_qy     <= i_coord_y[CW-1:0];
        end else if (w_rd_en) begin
            if (r_jphase) begin
                r_addr   <= '0;
                r_jphase <= 1'b0;
            end else begin
                r_addr <= r_addr + AW'(1);
                r_cnt  <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Read-data valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_rd   <= 1'b0;
            r_p1_edge <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
        end else begin
            r_p1_rd   <= w_rd_en;
            r_p1_edge <= w_rd_en && !r_jphase;
            r_s2_v    <= r_p1_edge;
            r_s3_v    <= r_s2_v;
        end
    end

    assign w_xi = r_rd_data[2*CW-1:CW];
    assign w_yi = r_rd_data[CW-1:0];
    assign w_xj = r_prev[2*CW-1:CW];
    assign w_yj = r_prev[CW-1:0];

    // Stage 2: hold the previous vertex, form differences and the straddle test
    always_ff @(posedge i_clk) begin
        if (r_p1_rd) begin
            r_prev <= r_rd_data;
        end
        r_s2_cross <= (w_yi > r_qy) != (w_yj > r_qy);
        r_s2_dpos  <= w_yj > w_yi;
        r_s2_a     <= {r_qx[CW-1], r_qx} - {w_xi[CW-1], w_xi};
        r_s2_d     <= {w_yj[CW-1], w_yj} - {w_yi[CW-1], w_yi};
        r_s2_b     <= {w_xj[CW-1], w_xj} - {w_xi[CW-1], w_xi};
        r_s2_e     <= {r_qy[CW-1], r_qy} - {w_yi[CW-1], w_yi};
    end

    // Stage 3: cross-multiply both sides of the crossing test
    always_ff @(posedge i_clk) begin
        r_s3_cross <= r_s2_cross;
        r_s3_dpos  <= r_s2_dpos;
        r_s3_pl    <= PW'(r_s2_a) * PW'(r_s2_d);
        r_s3_pr    <= PW'(r_s2_b) * PW'(r_s2_e);
    end

    // Left of crossing, with the relation flipped when yj is not above yi
    assign w_left = r_s3_dpos ? (r_s3_pl < r_s3_pr) : (r_s3_pr < r_s3_pl);

    // Toggle parity on each straddling edge the point lies left of
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_parity <= 1'b0;
        end else if (r_s3_v && r_s3_cross && w_left) begin
            r_parity <= !r_parity;
        end
    end

    // Output register: load at the end of a query, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_inside <= r_parity;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_inside;

    // The table is never written while a query walks it
    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_wr_en)
        else $error("vertex table written during a query");

    // The edge pipeline is empty whenever the sequencer is idle
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_p1_rd && !r_s2_v && !r_s3_v))
        else $error("edge pipeline busy while idle");

    // A result is only produced once the last edge has left the pipeline
    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (!r_s3_v && !r_s2_v && (r_state == ST_FINISH)))
        else $error("result loaded before the pipeline drained");

    // An edge is evaluated only on a read slot
    a_edge_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_edge |-> r_p1_rd)
        else $error("edge flag without a read");

endmodule

// File: bench/tb_top.sv
// Testbench for the even-odd point-in-polygon core: loads polygons, sends query points
// and checks every inside/outside result against an in-bench predictor of the same rule.
// Depends on pip_pkg and point_in_polygon_even_odd_core only.
`timescale 1ns / 1ps

module tb_top;
    import pip_pkg::*;

    localparam int          TABLE_SLOTS = 256;
    localparam logic [31:0] C_MIN       = 32'h8000_0000;
    localparam logic [31:0] C_MAX       = 32'h7fff_ffff;

    typedef enum int {
        SC_TINY,
        SC_MID,
        SC_WIDE,
        SC_EXTREME
    } t_coord_scale;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic               i_action       = ACT_LOAD;
    logic [IDX_W-1:0]   i_vertex_index = '0;
    logic               i_last_vertex  = 1'b0;
    logic [IN_CW-1:0]   i_coord_x      = '0;
    logic [IN_CW-1:0]   i_coord_y      = '0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic               o_inside_res;

    // Predictor copy of the vertex table and count
    logic signed [31:0] poly_x [TABLE_SLOTS];
    logic signed [31:0] poly_y [TABLE_SLOTS];
    bit                 slot_written [TABLE_SLOTS];
    logic [8:0]         poly_count = '0;

    logic               inside_expected [$];
    int                 err_count     = 0;
    int                 sent_reqs     = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    point_in_polygon_even_odd_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_vertex_index (i_vertex_index),
        .i_last_vertex  (i_last_vertex),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_inside_res   (o_inside_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic flag_err(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Even-odd ray cast over the stored polygon, exact cross-multiplied compare
    function automatic logic predict_inside(input logic signed [31:0] px,
                                            input logic signed [31:0] py);
        logic signed [65:0] spx, spy, xi, yi, xj, yj, d, lhs, rhs;
        logic               parity;
        logic               left;
        int                 n;
        int                 j;
        spx    = px;
        spy    = py;
        parity = 1'b0;
        n      = int'(poly_count);
        j      = n - 1;
        for (int i = 0; i < n; i++) begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if ((yi > spy) != (yj > spy)) begin
                d    = yj - yi;
                lhs  = (spx - xi) * d;
                rhs  = (xj - xi) * (spy - yi);
                left = (d > 0) ? (lhs < rhs) : (rhs < lhs);
                if (left) begin
                    parity = ~parity;
                end
            end
            j = i;
        end
        return parity;
    endfunction

    // Drop valid and wait for the clock before any wait that is not a request
    task automatic req_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send one request, then update the predictor at acceptance
    task automatic send_req(input logic act, input int idx, input logic last,
                            input logic [31:0] cx, input logic [31:0] cy);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_vertex_index <= IDX_W'(idx);
        i_last_vertex  <= last;
        i_coord_x      <= cx;
        i_coord_y      <= cy;
        do @(posedge i_clk); while (!o_ready);
        sent_reqs++;
        if (act == ACT_LOAD) begin
            poly_x[idx]       = cx;
            poly_y[idx]       = cy;
            slot_written[idx] = 1'b1;
            if (last) begin
                poly_count = 9'(idx + 1);
            end
        end else begin
            inside_expected.insert(inside_expected.size(), predict_inside(cx, cy));
        end
    endtask

    task automatic send_vertex(input int idx, input logic last,
                               input logic [31:0] cx, input logic [31:0] cy);
        send_req(ACT_LOAD, idx, last, cx, cy);
    endtask

    task automatic send_query(input logic [31:0] cx, input logic [31:0] cy);
        // vertex_index and last_vertex are don't-care on a query: randomize them
        send_req(ACT_QUERY, $urandom_range(255), 1'($urandom_range(1)), cx, cy);
    endtask

    function automatic logic [31:0] pick_coord(input t_coord_scale sc);
        logic [31:0] v;
        case (sc)
            SC_TINY: v = 32'($urandom_range(12)) - 32'd6;
            SC_MID:  v = 32'($urandom_range(131072)) - 32'd65536;
            SC_WIDE: v = $urandom;
            default: begin
                case ($urandom_range(5))
                    0:       v = C_MIN;
                    1:       v = C_MAX;
                    2:       v = '0;
                    3:       v = '1;
                    4:       v = 32'd1;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // Query near stored vertices often, so rays pass through vertices and edges
    task automatic send_probe(input t_coord_scale sc);
        logic [31:0] px, py;
        int          r;
        r = $urandom_range(99);
        if (poly_count != 0 && r < 40) begin
            px = poly_x[$urandom_range(int'(poly_count) - 1)] + 32'($urandom_range(2)) - 32'd1;
            py = poly_y[$urandom_range(int'(poly_count) - 1)];
        end else begin
            px = pick_coord(sc);
            py = pick_coord(sc);
        end
        send_query(px, py);
    endtask

    // Load slots 0 .. n-1, in order or shuffled; the flag rides on slot n-1
    task automatic load_polygon(input int n, input t_coord_scale sc, input bit shuffled,
                                input bit flag_last);
        int order [TABLE_SLOTS];
        int t;
        int s;
        for (int k = 0; k < n; k++) begin
            order[k] = k;
        end
        if (shuffled) begin
            for (int k = n - 1; k > 0; k--) begin
                s        = $urandom_range(k);
                t        = order[k];
                order[k] = order[s];
                order[s] = t;
            end
        end
        for (int k = 0; k < n; k++) begin
            send_vertex(order[k], flag_last && (order[k] == n - 1), pick_coord(sc),
                        pick_coord(sc));
        end
    endtask

    // Extremes, tiny shapes, and points on vertices and edges
    task automatic test_directed_shapes();
        send_query(32'd5, 32'd5);
        send_vertex(0, 1'b1, 32'd7, -32'sd3);
        send_query(32'd7, -32'sd3);
        send_query(32'd0, 32'd0);
        send_vertex(0, 1'b0, 32'd0, 32'd0);
        send_vertex(1, 1'b1, 32'd0, 32'd10);
        send_query(-32'sd1, 32'd5);
        send_vertex(0, 1'b0, C_MIN, C_MIN);
        send_vertex(1, 1'b0, C_MAX, C_MIN);
        send_vertex(2, 1'b1, 32'd0, C_MAX);
        send_query(32'd0, 32'd0);
        send_query(C_MIN, 32'd0);
        send_query(C_MAX, C_MAX);
        send_query(-32'sd1, C_MIN);
        send_vertex(0, 1'b0, 32'd0, 32'd0);
        send_vertex(1, 1'b0, 32'd4, 32'd0);
        send_vertex(2, 1'b0, 32'd4, 32'd4);
        send_vertex(3, 1'b1, 32'd0, 32'd4);
        send_query(32'd2, 32'd2);
        send_query(32'd0, 32'd2);
        send_query(32'd4, 32'd2);
        send_query(32'd2, 32'd0);
        send_query(32'd2, 32'd4);
        send_query(32'd4, 32'd4);
        req_idle();
    endtask

    // Mostly well-formed polygons with queries, plus partial loads and noise
    task automatic test_random_polygons(input int budget);
        int           stop_at;
        int           r;
        int           n;
        int           idx;
        bit           big_done;
        bit           ok;
        t_coord_scale sc;
        stop_at  = sent_reqs + budget;
        big_done = 1'b0;
        while (sent_reqs < stop_at) begin
            r  = $urandom_range(99);
            sc = t_coord_scale'($urandom_range(3));
            if (r < 85) begin
                n = $urandom_range(99);
                if (!big_done && n < 3) begin
                    n        = $urandom_range(64, 256);
                    big_done = 1'b1;
                end else if (n < 13) begin
                    n = $urandom_range(1, 2);
                end else if (n < 85) begin
                    n = $urandom_range(3, 10);
                end else begin
                    n = $urandom_range(11, 40);
                end
                // partial loads leave the old count in place
                if (r < 78) begin
                    load_polygon(n, sc, $urandom_range(4) == 0, 1'b1);
                end else begin
                    load_polygon($urandom_range(1, n), sc, 1'b0, 1'b0);
                end
                repeat ($urandom_range(1, 6)) send_probe(sc);
            end else if (r < 93) begin
                // stray load; flag it only when every lower slot holds data
                idx = $urandom_range(255);
                ok  = 1'b1;
                for (int k = 0; k < idx; k++) begin
                    if (!slot_written[k]) ok = 1'b0;
                end
                send_vertex(idx, ok && ($urandom_range(1) == 1), pick_coord(sc), pick_coord(sc));
            end else begin
                send_query(pick_coord(sc), pick_coord(sc));
            end
        end
        req_idle();
    endtask

    // Every table slot in use, top index included
    task automatic test_full_table();
        load_polygon(TABLE_SLOTS, SC_MID, 1'b0, 1'b1);
        repeat (6) send_probe(SC_MID);
        req_idle();
    endtask

    // Hold each query until the result channel is empty
    task automatic test_drain_pause();
        load_polygon(5, SC_TINY, 1'b0, 1'b1);
        repeat (4) begin
            req_idle();
            while (inside_expected.size() != 0) @(posedge i_clk);
            send_probe(SC_TINY);
        end
        req_idle();
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (inside_expected.size() == 0) begin
                flag_err($sformatf("unexpected result inside=%0b", o_inside_res));
            end else if (o_inside_res !== inside_expected[0]) begin
                flag_err($sformatf("mismatch: inside expected %0b got %0b",
                                   inside_expected[0], o_inside_res));
                void'(inside_expected.pop_front());
            end else begin
                void'(inside_expected.pop_front());
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_shapes();

        send_idle_pct = 13;
        recv_idle_pct = 68;
        test_random_polygons(400);
        test_full_table();

        send_idle_pct = 68;
        recv_idle_pct = 13;
        test_random_polygons(400);
        test_drain_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_polygons(400);

        // Drain, then allow one full-table walk for any stray result
        while (inside_expected.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
